### sv/cycle_phase_pi_pll_unit_defines.svh
// Assertion macros for the cycle phase PI loop checker.
// Depends on nothing; included by the checker file only.
`ifndef CYCLE_PHASE_PI_PLL_UNIT_DEFINES_SVH
`define CYCLE_PHASE_PI_PLL_UNIT_DEFINES_SVH

// Check a condition at every edge outside reset
`define CPP_ASSERT_HOLDS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check a consequence in the cycle after a condition, outside reset
`define CPP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// Check a consequence in the cycle after a condition, reset included
`define CPP_ASSERT_ALWAYS_NEXT(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

### sv/cpp_pkg.sv
// Shared types and constants of the cycle phase PI loop.
// Depends on nothing; used by the interfaces, the modulo unit, the top level, the checker and the testbench.
package cpp_pkg;

    localparam int TIME_W     = 64;
    localparam int PERIOD_W   = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Request kinds
    localparam logic REQ_SAMPLE  = 1'b0;
    localparam logic REQ_RESTART = 1'b1;

    // Register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PERIOD = 3'd0,
        CFG_ALPHA  = 3'd1,
        CFG_KP     = 3'd2,
        CFG_KI     = 3'd3,
        CFG_SLEW   = 3'd4,
        CFG_ILIM   = 3'd5,
        CFG_OLIM   = 3'd6,
        CFG_LBAND  = 3'd7
    } t_cfg_idx;

    // Register values after reset
    localparam logic [31:0] RST_PERIOD = 32'd1000000;
    localparam logic [16:0] RST_ALPHA  = 17'd6554;
    localparam logic [31:0] RST_KP     = 32'd32768;
    localparam logic [31:0] RST_KI     = 32'd655;
    localparam logic [30:0] RST_SLEW   = 31'd10000;
    localparam logic [30:0] RST_ILIM   = 31'd1000000;
    localparam logic [30:0] RST_OLIM   = 31'd100000;
    localparam logic [30:0] RST_LBAND  = 31'd1000;

    typedef struct packed {
        logic              req_type;
        logic [TIME_W-1:0] reference_time;
        logic              overran;
    } t_req;

    typedef struct packed {
        logic signed [31:0] deadline_adjust;
        logic signed [31:0] phase_error;
        logic               is_locked;
        logic               coasted;
    } t_res;

endpackage

### sv/cpp_req_if.sv
// Request channel of the cycle phase PI loop: valid, ready and a t_req payload.
// Depends on cpp_pkg.
interface cpp_req_if
    import cpp_pkg::*;
;
    logic valid;
    logic ready;
    t_req payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### sv/cpp_res_if.sv
// Result channel of the cycle phase PI loop: valid, ready and a t_res payload.
// Depends on cpp_pkg.
interface cpp_res_if
    import cpp_pkg::*;
;
    logic valid;
    logic ready;
    t_res payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### sv/cpp_div.sv
// Bit-serial restoring modulo unit: 64-bit dividend by 32-bit divisor, one bit a cycle.
// Depends on cpp_pkg.
module cpp_div
    import cpp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [TIME_W-1:0]   i_dividend,
    input  logic [PERIOD_W-1:0] i_divisor,
    output logic                o_done,
    output logic [PERIOD_W-1:0] o_rem
);
    localparam int C_W = $clog2(TIME_W);

    logic [TIME_W-1:0]   r_num;
    logic [PERIOD_W-1:0] r_den;
    logic [PERIOD_W-1:0] r_rem;
    logic [C_W-1:0]      r_cnt;
    logic                r_busy;
    logic                r_done;

    logic [PERIOD_W:0]   w_shift;
    logic [PERIOD_W:0]   w_sub;
    logic                w_ge;

    // Shift in the next dividend bit and subtract when it fits
    always_comb begin
        w_shift = {r_rem, r_num[TIME_W-1]};
        w_sub   = w_shift - {1'b0, r_den};
        w_ge    = (w_shift >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_num  <= i_dividend;
                r_den  <= i_divisor;
                r_rem  <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_num <= {r_num[TIME_W-2:0], 1'b0};
                r_rem <= w_ge ? w_sub[PERIOD_W-1:0] : w_shift[PERIOD_W-1:0];
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == C_W'(TIME_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;
endmodule

### sv/cpp_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit a cycle (B_W of at least 2).
// Depends on nothing.
module cpp_mul #(
    parameter int A_W = 48,
    parameter int B_W = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [A_W-1:0]     i_a,
    input  logic [B_W-1:0]     i_b,
    output logic               o_done,
    output logic [A_W+B_W-1:0] o_prod
);
    localparam int P_W = A_W + B_W;
    localparam int C_W = (B_W > 1) ? $clog2(B_W) : 1;

    logic [A_W-1:0] r_a;
    logic [B_W-1:0] r_b;
    logic [P_W-1:0] r_acc;
    logic [C_W-1:0] r_cnt;
    logic           r_busy;
    logic           r_done;
    logic [A_W:0]   w_sum;

    // Add the multiplicand into the upper half when the low multiplier bit is set
    assign w_sum = {1'b0, r_acc[P_W-1:B_W]} + (r_b[0] ? {1'b0, r_a} : {(A_W+1){1'b0}});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_a    <= i_a;
                r_b    <= i_b;
                r_acc  <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_acc <= {w_sum, r_acc[B_W-1:1]};
                r_b   <= r_b >> 1;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == C_W'(B_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;
endmodule

### sv/cycle_phase_pi_pll_unit.sv
// Top level of the cycle phase PI loop: registers, sequencer, loop state, result register.
// Depends on cpp_pkg, cpp_req_if, cpp_res_if, cpp_div and cpp_mul.
//
//  channel  | dir | handshake        | payload
//  i_req    | in  | valid / ready    | req_type, reference_time, overran
//  o_res    | out | valid / ready    | deadline_adjust, phase_error, is_locked, coasted
//  i_cfg_*  | in  | write enable     | register index, 32-bit write data
//
// A learning sample passes through the bit-serial modulo, the EMA multiply, the two
// parallel PI multiplies and the sequencing states before its result is registered.
// An EMA weight of one skips the EMA multiply. Rejected samples skip the learning steps;
// restart and zero-period requests go from idle straight to the result register.
// One request is worked on at a time; i_req.ready is high in the idle state. A result
// held back by o_res.ready waits in the output register; the next one then stalls input.
// Reset is synchronous and clears control and loop state; no clearing pass is needed.
module cycle_phase_pi_pll_unit
    import cpp_pkg::*;
#(
    parameter int UNLOCK_BAND_NS = 5000,
    parameter int ACQUIRE_RUN    = 16,
    parameter int RELEASE_RUN    = 16,
    parameter int ESCAPE_SAMPLES = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    cpp_req_if.sink               i_req,
    cpp_res_if.source             o_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);
    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_DIV  = 9'b000000010,
        S_ERR  = 9'b000000100,
        S_LRN  = 9'b000001000,
        S_EMA  = 9'b000010000,
        S_INT  = 9'b000100000,
        S_PI   = 9'b001000000,
        S_RND  = 9'b010000000,
        S_FIN  = 9'b100000000
    } t_state;

    localparam logic signed [49:0] EMA_HI   = 50'sh0_7FFF_FFFF_FFFF;
    localparam logic signed [49:0] EMA_LO   = 50'sh3_8000_0000_0000;
    localparam logic [63:0]        TERM_SAT = 64'h4000_0000_0000_0000;

    function automatic logic signed [47:0] f_sat_ema(input logic signed [49:0] v);
        logic signed [49:0] t;
        t = v;
        if (t > EMA_HI) t = EMA_HI;
        if (t < EMA_LO) t = EMA_LO;
        return t[47:0];
    endfunction

    // Configuration registers
    logic [31:0] r_period;
    logic [16:0] r_alpha;
    logic [31:0] r_kp;
    logic [31:0] r_ki;
    logic [30:0] r_slew;
    logic [30:0] r_ilim;
    logic [30:0] r_olim;
    logic [30:0] r_lband;

    // Loop state
    logic               r_tv;
    logic [31:0]        r_tgt;
    logic signed [47:0] r_filt;
    logic signed [32:0] r_int;
    logic signed [31:0] r_held;
    logic [7:0]         r_acq;
    logic [7:0]         r_rel;
    logic [7:0]         r_orun;
    logic               r_lock;
    logic               r_ever;

    // Sequencer and per-request work registers
    t_state             r_state;
    logic               r_ovr;
    logic signed [32:0] r_err;
    logic               r_dneg;
    logic [63:0]        r_u;
    t_res               r_res;
    t_res               r_out;
    logic               r_ov;

    logic        w_acc;
    logic        w_clear;

    logic        div_start;
    logic        div_done;
    logic [31:0] div_rem;

    logic        ema_start;
    logic        ema_done;
    logic [48:0] ema_a;
    logic [64:0] ema_prod;

    logic        pi_start;
    logic        kp_done;
    logic        ki_done;
    logic [47:0] w_me;
    logic [30:0] w_iabs;
    logic [79:0] kp_prod;
    logic [62:0] ki_prod;

    // Error path
    logic [31:0]        w_tgt;
    logic signed [34:0] w_e0, w_e1, w_e2, w_half, w_p, w_eabs;
    logic [31:0]        w_shown;
    logic               w_outlier;
    logic [7:0]         w_orun_inc;
    logic               w_escape;
    logic               w_reject;

    // Learning path
    logic signed [48:0] w_e16;
    logic signed [49:0] w_diff;
    logic [64:0]        w_qsum;
    logic signed [49:0] w_fnew;
    logic signed [34:0] w_isum, w_ilim;
    logic signed [32:0] w_inew;
    logic [63:0]        w_ta, w_tb, w_sa, w_sb;
    logic [63:0]        w_umag;
    logic [64:0]        w_nsum;
    logic [48:0]        w_n;
    logic [30:0]        w_ncl;
    logic signed [31:0] w_held;
    logic [31:0]        w_abs_ema;
    logic [7:0]         n_acq, n_rel;
    logic               n_lock, n_ever;

    assign w_acc   = i_req.valid && i_req.ready;
    assign w_clear = (w_acc && i_req.payload.req_type == REQ_RESTART) ||
                     (r_state == S_ERR && w_escape);

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= RST_PERIOD;
            r_alpha  <= RST_ALPHA;
            r_kp     <= RST_KP;
            r_ki     <= RST_KI;
            r_slew   <= RST_SLEW;
            r_ilim   <= RST_ILIM;
            r_olim   <= RST_OLIM;
            r_lband  <= RST_LBAND;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_PERIOD: r_period <= i_cfg_data;
                CFG_ALPHA:  r_alpha  <= i_cfg_data[16:0];
                CFG_KP:     r_kp     <= i_cfg_data;
                CFG_KI:     r_ki     <= i_cfg_data;
                CFG_SLEW:   r_slew   <= i_cfg_data[30:0];
                CFG_ILIM:   r_ilim   <= i_cfg_data[30:0];
                CFG_OLIM:   r_olim   <= i_cfg_data[30:0];
                CFG_LBAND:  r_lband  <= i_cfg_data[30:0];
                default:    r_lband  <= r_lband;
            endcase
        end
    end

    // Serial units
    assign div_start = w_acc && i_req.payload.req_type == REQ_SAMPLE && r_period != 32'd0;

    cpp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (i_req.payload.reference_time),
        .i_divisor  (r_period),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    cpp_mul #(.A_W(49), .B_W(16)) u_mul_ema (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (ema_start),
        .i_a     (ema_a),
        .i_b     (r_alpha[15:0]),
        .o_done  (ema_done),
        .o_prod  (ema_prod)
    );

    cpp_mul #(.A_W(48), .B_W(32)) u_mul_kp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (pi_start),
        .i_a     (w_me),
        .i_b     (r_kp),
        .o_done  (kp_done),
        .o_prod  (kp_prod)
    );

    cpp_mul #(.A_W(31), .B_W(32)) u_mul_ki (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (pi_start),
        .i_a     (w_iabs),
        .i_b     (r_ki),
        .o_done  (ki_done),
        .o_prod  (ki_prod)
    );

    // Wrap the phase error into half a period and classify the sample
    always_comb begin
        w_tgt      = r_tv ? r_tgt : div_rem;
        w_p        = $signed({3'b000, r_period});
        w_half     = $signed({4'b0000, r_period[31:1]});
        w_e0       = $signed({3'b000, div_rem}) - $signed({3'b000, w_tgt});
        w_e1       = (w_e0 > w_half) ? w_e0 - w_p : w_e0;
        w_e2       = (w_e1 <= -w_half) ? w_e1 + w_p : w_e1;
        w_eabs     = w_e2[34] ? -w_e2 : w_e2;
        w_shown    = (w_e2 > 35'sd2147483647) ? 32'h7FFF_FFFF : w_e2[31:0];
        w_outlier  = r_ever && (w_eabs[31:0] > {1'b0, r_olim});
        w_orun_inc = (r_orun == 8'hFF) ? r_orun : r_orun + 8'd1;
        w_escape   = w_outlier && (w_orun_inc >= 8'(ESCAPE_SAMPLES));
        w_reject   = r_ovr || w_outlier;
    end

    // EMA step and integrator
    always_comb begin
        w_e16   = {r_err, 16'h0000};
        w_diff  = {w_e16[48], w_e16} - {{2{r_filt[47]}}, r_filt};
        ema_a   = w_diff[49] ? 49'(-w_diff) : w_diff[48:0];
        w_qsum  = ema_prod + 65'd32768;
        w_fnew  = r_dneg ? r_filt - $signed({1'b0, w_qsum[64:16]})
                         : r_filt + $signed({1'b0, w_qsum[64:16]});
        w_isum  = {{2{r_int[32]}}, r_int} + {{2{r_err[32]}}, r_err};
        w_ilim  = $signed({4'b0000, r_ilim});
        w_inew  = (w_isum > w_ilim) ? w_ilim[32:0] :
                  (w_isum < -w_ilim) ? 33'(-w_ilim) : w_isum[32:0];
        w_iabs  = w_inew[32] ? 31'(-w_inew) : w_inew[30:0];
        w_me    = r_filt[47] ? 48'(-r_filt) : r_filt;
    end

    assign ema_start = (r_state == S_LRN) && !r_alpha[16];
    assign pi_start  = (r_state == S_INT);

    // PI law: saturate both terms, sum with wrap, round and clamp to the slew limit
    always_comb begin
        w_ta      = (kp_prod[79:16] > TERM_SAT) ? TERM_SAT : kp_prod[79:16];
        w_tb      = ({1'b0, ki_prod} > TERM_SAT) ? TERM_SAT : {1'b0, ki_prod};
        w_sa      = r_filt[47] ? -w_ta : w_ta;
        w_sb      = r_int[32] ? -w_tb : w_tb;
        w_umag    = r_u[63] ? -r_u : r_u;
        w_nsum    = {1'b0, w_umag} + 65'd32768;
        w_n       = w_nsum[64:16];
        w_ncl     = (w_n > {18'd0, r_slew}) ? r_slew : w_n[30:0];
        w_held    = r_u[63] ? -$signed({1'b0, w_ncl}) : $signed({1'b0, w_ncl});
        w_abs_ema = w_me[47:16];
    end

    // Lock detector next state
    always_comb begin
        n_acq  = r_acq;
        n_rel  = r_rel;
        n_lock = r_lock;
        n_ever = r_ever;
        if (!r_lock) begin
            if (w_abs_ema < {1'b0, r_lband}) begin
                n_acq = (r_acq == 8'hFF) ? r_acq : r_acq + 8'd1;
                if (n_acq >= 8'(ACQUIRE_RUN)) begin
                    n_lock = 1'b1;
                    n_ever = 1'b1;
                    n_rel  = 8'd0;
                end
            end else if (r_acq != 8'd0) begin
                n_acq = r_acq - 8'd1;
            end
        end else begin
            if (w_abs_ema > 32'(UNLOCK_BAND_NS)) begin
                n_rel = (r_rel == 8'hFF) ? r_rel : r_rel + 8'd1;
            end else begin
                n_rel = 8'd0;
            end
            if (n_rel >= 8'(RELEASE_RUN)) begin
                n_lock = 1'b0;
                n_acq  = 8'd0;
            end
        end
    end

    // Loop state updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_clear) begin
            r_tv   <= 1'b0;
            r_tgt  <= '0;
            r_filt <= '0;
            r_int  <= '0;
            r_held <= '0;
            r_acq  <= '0;
            r_rel  <= '0;
            r_orun <= '0;
            r_lock <= 1'b0;
            r_ever <= 1'b0;
        end else begin
            if (r_state == S_ERR) begin
                r_tv   <= 1'b1;
                r_tgt  <= w_tgt;
                r_orun <= w_outlier ? w_orun_inc : 8'd0;
            end
            if (r_state == S_LRN && r_alpha[16]) begin
                r_filt <= f_sat_ema({w_e16[48], w_e16});
            end
            if (r_state == S_EMA && ema_done) begin
                r_filt <= f_sat_ema(w_fnew);
            end
            if (r_state == S_INT) begin
                r_int <= w_inew;
            end
            if (r_state == S_RND) begin
                r_held <= w_held;
                r_acq  <= n_acq;
                r_rel  <= n_rel;
                r_lock <= n_lock;
                r_ever <= n_ever;
            end
        end
    end

    // Work registers of the request in flight
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_ovr <= i_req.payload.overran;
        end
        if (r_state == S_ERR) begin
            r_err <= w_e2[32:0];
        end
        if (ema_start) begin
            r_dneg <= w_diff[49];
        end
        if (r_state == S_PI && kp_done) begin
            r_u <= w_sa + w_sb;
        end
    end

    // Sequencer, result and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            if (r_ov && o_res.ready && r_state != S_FIN) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        if (i_req.payload.req_type == REQ_RESTART) begin
                            r_res   <= '0;
                            r_state <= S_FIN;
                        end else if (r_period == 32'd0) begin
                            r_res.deadline_adjust <= '0;
                            r_res.phase_error     <= '0;
                            r_res.is_locked       <= r_lock;
                            r_res.coasted         <= 1'b1;
                            r_state               <= S_FIN;
                        end else begin
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    if (div_done) r_state <= S_ERR;
                end
                S_ERR: begin
                    r_res.phase_error <= w_shown;
                    if (w_escape) begin
                        r_res.deadline_adjust <= '0;
                        r_res.is_locked       <= 1'b0;
                        r_res.coasted         <= 1'b1;
                        r_state               <= S_FIN;
                    end else if (w_reject) begin
                        r_res.deadline_adjust <= -r_held;
                        r_res.is_locked       <= r_lock;
                        r_res.coasted         <= 1'b1;
                        r_state               <= S_FIN;
                    end else begin
                        r_state <= S_LRN;
                    end
                end
                S_LRN: begin
                    r_state <= r_alpha[16] ? S_INT : S_EMA;
                end
                S_EMA: begin
                    if (ema_done) r_state <= S_INT;
                end
                S_INT: begin
                    r_state <= S_PI;
                end
                S_PI: begin
                    if (kp_done && ki_done) r_state <= S_RND;
                end
                S_RND: begin
                    r_res.deadline_adjust <= -w_held;
                    r_res.is_locked       <= n_lock;
                    r_res.coasted         <= 1'b0;
                    r_state               <= S_FIN;
                end
                S_FIN: begin
                    if (!r_ov || o_res.ready) begin
                        r_out   <= r_res;
                        r_ov    <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_req.ready   = (r_state == S_IDLE);
    assign o_res.valid   = r_ov;
    assign o_res.payload = r_out;
endmodule

### sv/cpp_checker.sv
// Port-level checker of the cycle phase PI loop result channel, with its bind.
// Depends on cpp_pkg and cycle_phase_pi_pll_unit_defines.svh.
`include "cycle_phase_pi_pll_unit_defines.svh"

module cpp_checker
    import cpp_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic i_ready,
    input t_res i_res
);
    // A stalled result stays offered
    `CPP_ASSERT_NEXT(a_valid_hold, i_clk, i_rst_n, i_valid && !i_ready, i_valid, "result dropped while stalled")

    // A stalled result keeps its fields
    `CPP_ASSERT_NEXT(a_data_hold, i_clk, i_rst_n, i_valid && !i_ready, $stable(i_res), "result changed while stalled")

    // The correction stays inside the symmetric 32-bit range
    `CPP_ASSERT_HOLDS(a_adj_range, i_clk, i_rst_n, !i_valid || i_res.deadline_adjust != 32'sh8000_0000, "deadline adjust out of range")

    // Reset leaves no result pending
    `CPP_ASSERT_ALWAYS_NEXT(a_rst_empty, i_clk, !i_rst_n, !i_valid, "result valid after reset")
endmodule

bind cycle_phase_pi_pll_unit cpp_checker u_cpp_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_res.valid),
    .i_ready (o_res.ready),
    .i_res   (o_res.payload)
);

### test/cycle_phase_pi_pll_unit_tb.sv
// Self-checking testbench for cycle_phase_pi_pll_unit: directed and random timestamp tracks
// against an internal bit-true loop predictor. Depends on cpp_pkg, cpp_req_if, cpp_res_if
// and the top level of the block.
module cycle_phase_pi_pll_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import cpp_pkg::*;

    localparam int UNLOCK_BAND = 5000;
    localparam int ACQ_SAMPLES = 16;
    localparam int REL_SAMPLES = 16;
    localparam int ESC_SAMPLES = 8;
    localparam int LATENCY     = 150;
    localparam int STALL_LEN   = 600;
    localparam longint EMA_HI   = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint EMA_LO   = -64'sh0000_8000_0000_0000;
    localparam bit [63:0] TERM_CAP = 64'h4000_0000_0000_0000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    cpp_req_if req_ch ();
    cpp_res_if res_ch ();

    cycle_phase_pi_pll_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_ch),
        .o_res      (res_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Register copy
    bit [31:0] reg_period;
    bit [16:0] reg_alpha;
    bit [31:0] reg_kp, reg_ki;
    bit [30:0] reg_slew, reg_ilim, reg_olim, reg_lband;

    // Loop state copy
    bit        tgt_valid;
    bit [31:0] tgt_phase;
    longint    ema, integ, held;
    bit [7:0]  acq_cnt, rel_cnt, out_run;
    bit        locked, ever_locked;

    t_req pending_req[$];
    t_res expected_res[$];

    int unsigned snd_idle, rcv_idle;
    int          failures, n_accepted, n_checked, n_locked, n_coasted;
    int          stall_asked, stall_served, stall_cnt;

    function automatic bit [63:0] mag(input longint v);
        bit [63:0] u;
        u = v;
        return (v < 0) ? (64'd0 - u) : u;
    endfunction

    function automatic void clear_loop_state();
        tgt_valid = 0; tgt_phase = 0; ema = 0; integ = 0; held = 0;
        acq_cnt = 0; rel_cnt = 0; out_run = 0; locked = 0; ever_locked = 0;
    endfunction

    // Update filter, integrator, correction and lock detector on an accepted error
    function automatic void learn_error(input longint err);
        longint    e16, diff, lim, sa, sb, u;
        bit [63:0] q, me, ta, tb, n, abs_ema;
        e16 = err * 65536;
        if (reg_alpha >= 65536) begin
            ema = e16;
        end else begin
            diff = e16 - ema;
            q = (mag(diff) * {47'd0, reg_alpha} + 64'd32768) >> 16;
            ema = (diff < 0) ? ema - $signed(q) : ema + $signed(q);
        end
        if (ema > EMA_HI) ema = EMA_HI;
        if (ema < EMA_LO) ema = EMA_LO;

        lim = reg_ilim;
        integ = integ + err;
        if (integ > lim) integ = lim;
        if (integ < -lim) integ = -lim;

        me = mag(ema);
        ta = {32'd0, reg_kp} * (me >> 16) + (({32'd0, reg_kp} * (me & 64'hFFFF)) >> 16);
        tb = {32'd0, reg_ki} * mag(integ);
        if (ta > TERM_CAP) ta = TERM_CAP;
        if (tb > TERM_CAP) tb = TERM_CAP;
        sa = (ema < 0) ? -$signed(ta) : $signed(ta);
        sb = (integ < 0) ? -$signed(tb) : $signed(tb);
        u = sa + sb;
        n = (mag(u) + 64'd32768) >> 16;
        if (n > {33'd0, reg_slew}) n = {33'd0, reg_slew};
        held = (u < 0) ? -$signed(n) : $signed(n);

        abs_ema = me >> 16;
        if (!locked) begin
            if (abs_ema < {33'd0, reg_lband}) begin
                if (acq_cnt < 255) acq_cnt++;
                if (acq_cnt >= ACQ_SAMPLES) begin
                    locked = 1; ever_locked = 1; rel_cnt = 0;
                end
            end else if (acq_cnt > 0) begin
                acq_cnt--;
            end
        end else begin
            if (abs_ema > UNLOCK_BAND) begin
                if (rel_cnt < 255) rel_cnt++;
            end else begin
                rel_cnt = 0;
            end
            if (rel_cnt >= REL_SAMPLES) begin
                locked = 0; acq_cnt = 0;
            end
        end
    endfunction

    // Work out the result of one request and advance the loop state
    function automatic t_res predict_result(input t_req r);
        t_res      res;
        bit [63:0] phase;
        longint    lp, lt, p, half, err, shown;
        bit        reject;
        res = '0;
        if (r.req_type == REQ_RESTART) begin
            clear_loop_state();
            return res;
        end
        if (reg_period == 0) begin
            res.is_locked = locked;
            res.coasted = 1'b1;
            return res;
        end
        phase = r.reference_time % {32'd0, reg_period};
        if (!tgt_valid) begin
            tgt_phase = phase[31:0];
            tgt_valid = 1;
        end
        lp = phase; lt = tgt_phase; p = reg_period; half = reg_period / 2;
        err = lp - lt;
        if (err > half) err = err - p;
        if (err <= -half) err = err + p;

        reject = r.overran;
        if (ever_locked && mag(err) > {33'd0, reg_olim}) begin
            reject = 1;
            if (out_run < 255) out_run++;
            if (out_run >= ESC_SAMPLES) clear_loop_state();
        end else begin
            out_run = 0;
        end
        if (!reject) learn_error(err);

        shown = (err > 2147483647) ? 2147483647 : err;
        res.deadline_adjust = 32'(-held);
        res.phase_error = shown[31:0];
        res.is_locked = locked;
        res.coasted = reject;
        return res;
    endfunction

    // Request driver: hold an offered request until taken, then offer the next
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                expected_res.push_back(predict_result(req_ch.payload));
                void'(pending_req.pop_front());
                n_accepted++;
            end
            if (req_ch.valid && !req_ch.ready) begin
                // hold
            end else if (pending_req.size() != 0 && $urandom_range(99) >= snd_idle) begin
                req_ch.valid   <= 1'b1;
                req_ch.payload <= pending_req[0];
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, counted here
    always @(posedge i_clk) begin
        if (stall_cnt != 0) begin
            stall_cnt <= stall_cnt - 1;
        end else if (stall_served != stall_asked) begin
            stall_cnt    <= STALL_LEN;
            stall_served <= stall_served + 1;
        end
    end

    // Result monitor: compare each taken result with the oldest expectation
    always @(posedge i_clk) begin
        t_res e;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (expected_res.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, res_ch.payload);
                    failures++;
                end else begin
                    e = expected_res.pop_front();
                    n_checked++;
                    if (e.is_locked) n_locked++;
                    if (e.coasted) n_coasted++;
                    if (res_ch.payload.deadline_adjust !== e.deadline_adjust) begin
                        $display("%0t: deadline_adjust expected %0d actual %0d", $time,
                                 e.deadline_adjust, res_ch.payload.deadline_adjust);
                        failures++;
                    end
                    if (res_ch.payload.phase_error !== e.phase_error) begin
                        $display("%0t: phase_error expected %0d actual %0d", $time,
                                 e.phase_error, res_ch.payload.phase_error);
                        failures++;
                    end
                    if (res_ch.payload.is_locked !== e.is_locked) begin
                        $display("%0t: is_locked expected %0b actual %0b", $time,
                                 e.is_locked, res_ch.payload.is_locked);
                        failures++;
                    end
                    if (res_ch.payload.coasted !== e.coasted) begin
                        $display("%0t: coasted expected %0b actual %0b", $time,
                                 e.coasted, res_ch.payload.coasted);
                        failures++;
                    end
                end
            end
            res_ch.ready <= (stall_cnt == 0) && ($urandom_range(99) >= rcv_idle);
        end
    end

    task automatic write_reg(input t_cfg_idx idx, input bit [31:0] v);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= v;
        case (idx)
            CFG_PERIOD: reg_period = v;
            CFG_ALPHA:  reg_alpha  = v[16:0];
            CFG_KP:     reg_kp     = v;
            CFG_KI:     reg_ki     = v;
            CFG_SLEW:   reg_slew   = v[30:0];
            CFG_ILIM:   reg_ilim   = v[30:0];
            CFG_OLIM:   reg_olim   = v[30:0];
            default:    reg_lband  = v[30:0];
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_regs(input bit [31:0] per, input bit [31:0] alpha, input bit [31:0] kp,
                            input bit [31:0] ki, input bit [31:0] slew, input bit [31:0] ilim,
                            input bit [31:0] olim, input bit [31:0] lband);
        write_reg(CFG_PERIOD, per);
        write_reg(CFG_ALPHA, alpha);
        write_reg(CFG_KP, kp);
        write_reg(CFG_KI, ki);
        write_reg(CFG_SLEW, slew);
        write_reg(CFG_ILIM, ilim);
        write_reg(CFG_OLIM, olim);
        write_reg(CFG_LBAND, lband);
    endtask

    task automatic set_random_regs();
        set_regs($urandom_range(2000000, 1000), $urandom_range(65536, 0),
                 $urandom_range(200000, 0), $urandom_range(5000, 0),
                 $urandom_range(100000, 1), $urandom_range(2000000, 0),
                 $urandom_range(500000, 1000), $urandom_range(5000, 200));
    endtask

    function automatic void push_req(input logic kind, input bit [63:0] t, input logic ovr);
        t_req r;
        r.req_type = kind;
        r.reference_time = t;
        r.overran = ovr;
        pending_req.push_back(r);
    endfunction

    // Timestamps on the cycle grid with jitter, overruns, stray samples and, when asked, an outlier burst
    task automatic add_track(input int n, input int unsigned wild_pct, input int unsigned ovr_pct,
                             input bit burst);
        bit [63:0]   t, per;
        int unsigned jit;
        int          j;
        per = (reg_period == 0) ? 64'd1000 : {32'd0, reg_period};
        jit = reg_lband / 2;
        if (jit > per / 8) jit = per / 8;
        if (jit > 20000) jit = 20000;
        t = {$urandom, $urandom};
        push_req(REQ_RESTART, t, 1'b0);
        for (int k = 0; k < n; k++) begin
            t = t + per;
            j = $signed($urandom_range(2 * jit, 0)) - $signed(jit);
            if (burst && k == n / 2) begin
                repeat (ESC_SAMPLES + 1) push_req(REQ_SAMPLE, t + $urandom, 1'b0);
            end
            if ($urandom_range(99) < wild_pct) begin
                push_req(REQ_SAMPLE, t + $urandom, $urandom_range(1));
            end else begin
                push_req(REQ_SAMPLE, t + 64'($signed(j)), $urandom_range(99) < ovr_pct);
            end
        end
    endtask

    task automatic add_noise(input int n);
        repeat (n) push_req($urandom_range(99) < 5, {$urandom, $urandom}, $urandom_range(1));
    endtask

    task automatic drain();
        while (pending_req.size() != 0 || expected_res.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic run_phase();
        add_track(100, 3, 3, 1'b1);
        add_noise(25);
        add_track(100, 5, 5, 1'b0);
        drain();
    endtask

    initial begin
        req_ch.valid = 1'b0;
        req_ch.payload = '0;
        res_ch.ready = 1'b0;
        reg_period = RST_PERIOD; reg_alpha = RST_ALPHA; reg_kp = RST_KP; reg_ki = RST_KI;
        reg_slew = RST_SLEW; reg_ilim = RST_ILIM; reg_olim = RST_OLIM; reg_lband = RST_LBAND;
        clear_loop_state();
        snd_idle = 14;
        rcv_idle = 88;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Reset values: extremes of the time field, overrun, error wrap at half a period
        push_req(REQ_RESTART, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        push_req(REQ_SAMPLE, 64'd0, 1'b0);
        push_req(REQ_SAMPLE, 64'd500000, 1'b0);
        push_req(REQ_SAMPLE, 64'd500001, 1'b0);
        push_req(REQ_SAMPLE, 64'd1499999, 1'b0);
        push_req(REQ_SAMPLE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        push_req(REQ_SAMPLE, 64'd2000100, 1'b1);
        push_req(REQ_SAMPLE, 64'd3000000, 1'b0);
        run_phase();

        // All gains and limits at their top, outlier limit zero; then full gains with tight outlier and lock limits
        set_regs(1000, 131071, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF);
        run_phase();
        set_regs(1000, 65536, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 200, 500);
        run_phase();

        // Zero period disables updates
        snd_idle = 88;
        rcv_idle = 14;
        write_reg(CFG_PERIOD, 0);
        add_noise(30);
        drain();

        // Widest period, every gain and limit but the outlier limit at zero; errors at the edges of the output range
        set_regs(32'hFFFF_FFFF, 0, 0, 0, 0, 0, 32'h7FFF_FFFF, 0);
        push_req(REQ_RESTART, 64'd0, 1'b0);
        push_req(REQ_SAMPLE, 64'd0, 1'b0);
        push_req(REQ_SAMPLE, 64'h8000_0000, 1'b0);
        push_req(REQ_SAMPLE, 64'h7FFF_FFFF, 1'b0);
        push_req(REQ_SAMPLE, 64'h8000_0001, 1'b0);
        push_req(REQ_SAMPLE, 64'hFFFF_FFFE, 1'b0);
        push_req(REQ_SAMPLE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        run_phase();

        set_random_regs();
        run_phase();

        // No idling, and one long receiver hold-off while requests keep coming
        snd_idle = 0;
        rcv_idle = 0;
        set_regs(RST_PERIOD, RST_ALPHA, RST_KP, RST_KI, RST_SLEW, RST_ILIM, RST_OLIM, RST_LBAND);
        stall_asked = 1;
        run_phase();
        set_random_regs();
        run_phase();
        set_random_regs();
        run_phase();

        while (pending_req.size() != 0 || expected_res.size() != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
        $display("Checked %0d results of %0d requests across 9 register settings;",
                 n_checked, n_accepted);
        $display("%0d results reported lock and %0d were coasted.", n_locked, n_coasted);
        if (failures == 0) begin
            $display("cycle_phase_pi_pll_unit: match");
        end else begin
            $display("cycle_phase_pi_pll_unit: mismatch");
        end
        $finish;
    end

    // Run limit
    initial begin
        #60_000_000;
        $display("Timeout with %0d requests still pending", pending_req.size());
        $display("cycle_phase_pi_pll_unit: mismatch");
        $finish;
    end
endmodule
